// ----- hdl/balance_robot_motor_controller_defines.svh -----
// Assertion macros shared by the balance controller RTL.
`ifndef BALANCE_ROBOT_MOTOR_CONTROLLER_DEFINES_SVH
`define BALANCE_ROBOT_MOTOR_CONTROLLER_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define BRMC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BRMC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BRMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/brmc_pkg.sv -----
// Types, constants and helper functions for the balance controller.
package brmc_pkg;

    // Loop limits
    localparam int SPEED_TARGET_LIMIT = 3;
    localparam int TURN_TARGET_LIMIT  = 2000;
    localparam int INTEGRAL_LIMIT     = 10000;
    localparam int YAW_BIAS           = 23;
    localparam int TURN_STEP          = 3;

    // State widths
    localparam int ST_W = 3;
    localparam int TT_W = 12;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 21;

    // Shared multiply-accumulate unit
    localparam int MAC_A_W = 32;
    localparam int MAC_B_W = 21;
    localparam int MAC_P_W = MAC_A_W + MAC_B_W;
    localparam int ACC_W   = 56;

    // Divide-by-five unit, one hex digit per step
    localparam int DIV_W       = 40;
    localparam int DIV_DIGIT_W = 4;
    localparam int DIV_STEPS   = DIV_W / DIV_DIGIT_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int DIV_REM_W   = 3;
    localparam int DIV_OFS_EXP = 35;
    // Dividend bias, a multiple of five that lifts the filter sum above zero
    localparam logic [DIV_W-1:0] DIV_OFFSET  = DIV_W'(5) << DIV_OFS_EXP;
    localparam logic [DIV_W-1:0] QUOT_OFFSET = DIV_W'(1) << DIV_OFS_EXP;

    // Register reset values
    localparam logic signed [16:0] ANGLE_ZERO_RST = -17'sd512;
    localparam logic signed [20:0] BAL_P_RST      = -21'sd102400;
    localparam logic signed [16:0] BAL_D_RST      = -17'sd205;
    localparam logic signed [20:0] SPD_P_RST      = 21'sd115200;
    localparam logic signed [16:0] SPD_I_RST      = 17'sd576;
    localparam logic signed [16:0] TURN_P_RST     = -17'sd179;
    localparam logic signed [16:0] TURN_D_RST     = 17'sd179;
    localparam logic [14:0]        OUT_LIMIT_RST  = 15'd6900;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ANGLE_ZERO   = 3'd0,
        CFG_BAL_P_GAIN   = 3'd1,
        CFG_BAL_D_GAIN   = 3'd2,
        CFG_SPD_P_GAIN   = 3'd3,
        CFG_SPD_I_GAIN   = 3'd4,
        CFG_TURN_P_GAIN  = 3'd5,
        CFG_TURN_D_GAIN  = 3'd6,
        CFG_OUTPUT_LIMIT = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BAL_P,
        S_BAL_D,
        S_TURN_P,
        S_TURN_D,
        S_TURN_SUM,
        S_DIV_WAIT,
        S_FILT,
        S_INTEG,
        S_SPD_I,
        S_SPD_SUM,
        S_VEL,
        S_MIX,
        S_OUT
    } t_state;

    typedef struct packed {
        logic acc_load;
        logic acc_add;
        logic acc_shl8;
    } t_mac_ctl;

    // Quotient digit of a value below 80 divided by five
    function automatic logic [DIV_DIGIT_W-1:0] div5_digit(
        input logic [DIV_REM_W+DIV_DIGIT_W-1:0] v
    );
        logic [DIV_DIGIT_W-1:0] d;
        d = '0;
        for (int k = 1; k < (1 << DIV_DIGIT_W); k++) begin
            if (v >= (DIV_REM_W + DIV_DIGIT_W)'(5 * k)) begin
                d = DIV_DIGIT_W'(k);
            end
        end
        return d;
    endfunction

    // Arithmetic shift right that rounds toward zero
    function automatic logic signed [ACC_W-1:0] trunc_shr(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             sh
    );
        logic signed [ACC_W-1:0] bias;
        bias = (ACC_W'(1) << sh) - ACC_W'(1);
        return v[ACC_W-1] ? ((v + bias) >>> sh) : (v >>> sh);
    endfunction

endpackage

// ----- hdl/brmc_mac.sv -----
// Shared signed multiplier with a registered product and an accumulator.
module brmc_mac (
    input  logic                               i_clk,
    input  brmc_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [brmc_pkg::MAC_A_W-1:0] i_a,
    input  logic signed [brmc_pkg::MAC_B_W-1:0] i_b,
    output logic signed [brmc_pkg::ACC_W-1:0]   o_acc
);
    import brmc_pkg::*;

    logic signed [MAC_P_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   addend;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Scale the product by 256 when asked
    always_comb begin
        if (i_ctl.acc_shl8) begin
            addend = {r_prod[ACC_W-9:0], 8'd0};
        end else begin
            addend = ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_load) begin
            r_acc <= addend;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + addend;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- hdl/brmc_div5.sv -----
// Digit-serial divide by five, one hex digit of quotient per cycle.
module brmc_div5 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [brmc_pkg::DIV_W-1:0]  i_dividend,
    output logic                        o_busy,
    output logic [brmc_pkg::DIV_W-1:0]  o_quotient
);
    import brmc_pkg::*;

    logic [DIV_W-1:0]               r_dividend;
    logic [DIV_W-1:0]               r_quot;
    logic [DIV_REM_W-1:0]           r_rem;
    logic [DIV_CNT_W-1:0]           r_cnt;
    logic [DIV_REM_W+DIV_DIGIT_W-1:0] part;
    logic [DIV_REM_W+DIV_DIGIT_W-1:0] sub;
    logic [DIV_DIGIT_W-1:0]         digit;
    logic [DIV_REM_W-1:0]           n_rem;

    // Bring down the next digit behind the running remainder
    always_comb begin
        part  = {r_rem, r_dividend[DIV_W-1 -: DIV_DIGIT_W]};
        digit = div5_digit(part);
        sub   = ((DIV_REM_W + DIV_DIGIT_W)'(digit) << 2) + (DIV_REM_W + DIV_DIGIT_W)'(digit);
        n_rem = DIV_REM_W'(part - sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dividend <= i_dividend;
            r_quot     <= '0;
            r_rem      <= '0;
        end else if (r_cnt != '0) begin
            r_dividend <= r_dividend << DIV_DIGIT_W;
            r_quot     <= {r_quot[DIV_W-DIV_DIGIT_W-1:0], digit};
            r_rem      <= n_rem;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quot;

endmodule

// ----- hdl/balance_robot_motor_controller.sv -----
// Per item: S_BAL_P, S_BAL_D, S_TURN_P, S_TURN_D, S_TURN_SUM, S_DIV_WAIT, S_FILT, S_INTEG,
// S_SPD_I, S_SPD_SUM, S_VEL, S_MIX, S_OUT. The ten-step divide by five of the speed filter
// can hold S_DIV_WAIT, a stalled output S_OUT; the shared multiplier is used six times.
// o_ready is high only while the sequencer is idle; a result may wait in the output register.
// Reset (i_rst_n low, synchronous): registers to defaults, loop state to zero, output empty.
// No clearing pass: the block is ready as soon as reset is released.
`include "balance_robot_motor_controller_defines.svh"

module balance_robot_motor_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [16:0]                 i_pitch_angle,
    input  logic signed [15:0]                 i_pitch_rate,
    input  logic signed [15:0]                 i_yaw_rate,
    input  logic signed [15:0]                 i_encoder_a_raw,
    input  logic signed [15:0]                 i_encoder_b_raw,
    input  logic                               i_speed_up,
    input  logic                               i_speed_down,
    input  logic                               i_turn_left,
    input  logic                               i_turn_right,
    // output channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_motor_a_reverse,
    output logic [14:0]                        o_motor_a_duty,
    output logic                               o_motor_b_reverse,
    output logic [14:0]                        o_motor_b_duty,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [brmc_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [brmc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import brmc_pkg::*;

    localparam logic signed [ST_W:0]   ST_MAX    = (ST_W + 1)'(SPEED_TARGET_LIMIT);
    localparam logic signed [TT_W:0]   TT_MAX    = (TT_W + 1)'(TURN_TARGET_LIMIT);
    localparam logic signed [TT_W:0]   TT_STEP   = (TT_W + 1)'(TURN_STEP);
    localparam logic signed [32:0]     INTEG_MAX = 33'(longint'(INTEGRAL_LIMIT) * 65536);
    localparam logic signed [16:0]     YAW_OFS   = 17'(YAW_BIAS);
    localparam logic signed [DIV_W-1:0] Q_MAX    = DIV_W'(32'h7FFF_FFFF);
    localparam logic signed [DIV_W-1:0] Q_MIN    = -DIV_W'(64'h8000_0000);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [16:0] r_angle_zero;
    logic signed [20:0] r_bal_p_gain;
    logic signed [16:0] r_bal_d_gain;
    logic signed [20:0] r_spd_p_gain;
    logic signed [16:0] r_spd_i_gain;
    logic signed [16:0] r_turn_p_gain;
    logic signed [16:0] r_turn_d_gain;
    logic [14:0]        r_output_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_zero   <= ANGLE_ZERO_RST;
            r_bal_p_gain   <= BAL_P_RST;
            r_bal_d_gain   <= BAL_D_RST;
            r_spd_p_gain   <= SPD_P_RST;
            r_spd_i_gain   <= SPD_I_RST;
            r_turn_p_gain  <= TURN_P_RST;
            r_turn_d_gain  <= TURN_D_RST;
            r_output_limit <= OUT_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_ANGLE_ZERO:   r_angle_zero   <= i_cfg_wdata[16:0];
                CFG_BAL_P_GAIN:   r_bal_p_gain   <= i_cfg_wdata[20:0];
                CFG_BAL_D_GAIN:   r_bal_d_gain   <= i_cfg_wdata[16:0];
                CFG_SPD_P_GAIN:   r_spd_p_gain   <= i_cfg_wdata[20:0];
                CFG_SPD_I_GAIN:   r_spd_i_gain   <= i_cfg_wdata[16:0];
                CFG_TURN_P_GAIN:  r_turn_p_gain  <= i_cfg_wdata[16:0];
                CFG_TURN_D_GAIN:  r_turn_d_gain  <= i_cfg_wdata[16:0];
                CFG_OUTPUT_LIMIT: r_output_limit <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and shared units
    // ------------------------------------------------------------------
    t_state                    r_state, n_state;
    t_mac_ctl                  mac_ctl;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   mac_acc;
    logic                      div_busy;
    logic [DIV_W-1:0]          div_quot;
    logic                      accept;
    logic                      out_load;

    // Loop state kept across ticks
    logic signed [ST_W-1:0]    r_speed_target;
    logic signed [TT_W-1:0]    r_turn_target;
    logic signed [31:0]        r_filt;
    logic signed [31:0]        r_integ;

    // Operands latched at the transfer
    logic signed [17:0]        r_angle_diff;
    logic signed [15:0]        r_pitch_rate;
    logic signed [16:0]        r_yaw_err;
    logic signed [16:0]        r_turn_kp;

    // Terms
    logic signed [27:0]        r_bal;
    logic signed [27:0]        r_trn;
    logic signed [29:0]        r_vel;
    logic signed [31:0]        r_mix_a;
    logic signed [31:0]        r_mix_b;

    // Output register
    logic                      r_out_valid;
    logic                      r_a_rev, r_b_rev;
    logic [14:0]               r_a_duty, r_b_duty;

    assign accept   = i_valid && o_ready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Each state issues at most one multiply; the MAC registers the product, and in the
    // following cycle it is loaded into or added to the accumulator.
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_BAL_P;
                end
            end
            S_BAL_P: begin
                mac_a   = MAC_A_W'(r_angle_diff);
                mac_b   = r_bal_p_gain;
                n_state = S_BAL_D;
            end
            S_BAL_D: begin
                mac_a           = MAC_A_W'(r_pitch_rate);
                mac_b           = MAC_B_W'(r_bal_d_gain);
                mac_ctl.acc_load = 1'b1;
                n_state         = S_TURN_P;
            end
            S_TURN_P: begin
                mac_a            = MAC_A_W'(r_yaw_err);
                mac_b            = MAC_B_W'(r_turn_kp);
                mac_ctl.acc_add  = 1'b1;
                mac_ctl.acc_shl8 = 1'b1;
                n_state          = S_TURN_D;
            end
            S_TURN_D: begin
                mac_a            = MAC_A_W'(r_turn_target);
                mac_b            = MAC_B_W'(r_turn_d_gain);
                mac_ctl.acc_load = 1'b1;
                n_state          = S_TURN_SUM;
            end
            S_TURN_SUM: begin
                mac_ctl.acc_add = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!div_busy) begin
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                n_state = S_INTEG;
            end
            S_INTEG: begin
                mac_a   = r_filt;
                mac_b   = r_spd_p_gain;
                n_state = S_SPD_I;
            end
            S_SPD_I: begin
                mac_a            = r_integ;
                mac_b            = MAC_B_W'(r_spd_i_gain);
                mac_ctl.acc_load = 1'b1;
                n_state          = S_SPD_SUM;
            end
            S_SPD_SUM: begin
                mac_ctl.acc_add = 1'b1;
                n_state         = S_VEL;
            end
            S_VEL: begin
                n_state = S_MIX;
            end
            S_MIX: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    brmc_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (mac_acc)
    );

    // ------------------------------------------------------------------
    // Button targets and filter dividend, formed in the transfer cycle
    // ------------------------------------------------------------------
    logic signed [ST_W:0]      st_step;
    logic signed [ST_W-1:0]    n_speed_target;
    logic signed [TT_W:0]      tt_step;
    logic signed [TT_W-1:0]    n_turn_target;
    logic signed [17:0]        speed_err;
    logic signed [35:0]        filt_sum;
    logic [DIV_W-1:0]          n_dividend;

    always_comb begin
        // Speed target: step, pin at the limit while pushing, drop to zero on release
        st_step = (ST_W + 1)'(r_speed_target)
                + (i_speed_up   ? (ST_W + 1)'(1) : '0)
                - (i_speed_down ? (ST_W + 1)'(1) : '0);
        if (i_speed_up && (st_step >= ST_MAX)) begin
            st_step = ST_MAX;
        end
        if (i_speed_down && (st_step <= -ST_MAX)) begin
            st_step = -ST_MAX;
        end
        if (!i_speed_up && !i_speed_down) begin
            st_step = '0;
        end
        n_speed_target = ST_W'(st_step);

        // Turn target: ramp while a button is held, clamp, clear on release
        tt_step = (i_turn_left || i_turn_right) ? (TT_W + 1)'(r_turn_target) : '0;
        if (i_turn_left) begin
            tt_step = tt_step + TT_STEP;
        end
        if (i_turn_right) begin
            tt_step = tt_step - TT_STEP;
        end
        if (tt_step >= TT_MAX) begin
            tt_step = TT_MAX;
        end
        if (tt_step <= -TT_MAX) begin
            tt_step = -TT_MAX;
        end
        n_turn_target = TT_W'(tt_step);

        // Filter: new = floor((4*old + err*2^16 + 2) / 5); the bias keeps the
        // dividend positive so the divider can run unsigned.
        speed_err  = 18'(i_encoder_b_raw) - 18'(i_encoder_a_raw) - 18'(n_speed_target);
        filt_sum   = (36'(r_filt) <<< 2) + (36'(speed_err) <<< 16);
        n_dividend = {{(DIV_W - 36){filt_sum[35]}}, filt_sum} + DIV_W'(2) + DIV_OFFSET;
    end

    brmc_div5 u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (n_dividend),
        .o_busy     (div_busy),
        .o_quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Loop state
    // ------------------------------------------------------------------
    logic signed [DIV_W-1:0]   quot_s;
    logic signed [31:0]        filt_sat;
    logic signed [32:0]        integ_sum;
    logic signed [31:0]        integ_sat;

    always_comb begin
        // Remove the bias and saturate to 32 bits
        quot_s = $signed(div_quot - QUOT_OFFSET);
        if (quot_s > Q_MAX) begin
            filt_sat = 32'sh7FFF_FFFF;
        end else if (quot_s < Q_MIN) begin
            filt_sat = 32'sh8000_0000;
        end else begin
            filt_sat = quot_s[31:0];
        end

        integ_sum = 33'(r_integ) + 33'(r_filt);
        if (integ_sum > INTEG_MAX) begin
            integ_sat = 32'(INTEG_MAX);
        end else if (integ_sum < -INTEG_MAX) begin
            integ_sat = 32'(-INTEG_MAX);
        end else begin
            integ_sat = integ_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_target <= '0;
            r_turn_target  <= '0;
            r_filt         <= '0;
            r_integ        <= '0;
        end else begin
            if (accept) begin
                r_speed_target <= n_speed_target;
                r_turn_target  <= n_turn_target;
            end
            if (r_state == S_FILT) begin
                r_filt <= filt_sat;
            end
            if (r_state == S_INTEG) begin
                r_integ <= integ_sat;
            end
        end
    end

    // ------------------------------------------------------------------
    // Operand capture and term results
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]   acc_q16;
    logic signed [ACC_W-1:0]   acc_q8;
    logic signed [ACC_W-1:0]   acc_q24;

    always_comb begin
        acc_q16 = trunc_shr(mac_acc, 16);
        acc_q8  = trunc_shr(mac_acc, 8);
        acc_q24 = trunc_shr(mac_acc, 24);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_angle_diff <= 18'(i_pitch_angle) - 18'(r_angle_zero);
            r_pitch_rate <= i_pitch_rate;
            r_yaw_err    <= 17'(i_yaw_rate) - YAW_OFS;
            // P gain on yaw is off while turning
            r_turn_kp    <= (i_turn_left || i_turn_right) ? '0 : r_turn_p_gain;
        end
        // Balance sum sits in the accumulator during S_TURN_D
        if (r_state == S_TURN_D) begin
            r_bal <= acc_q16[27:0];
        end
        // Turn sum is stable for the whole divider wait
        if (r_state == S_DIV_WAIT) begin
            r_trn <= acc_q8[27:0];
        end
        if (r_state == S_VEL) begin
            r_vel <= acc_q24[29:0];
        end
        if (r_state == S_MIX) begin
            r_mix_a <= 32'(r_bal) - 32'(r_vel) + 32'(r_trn);
            r_mix_b <= 32'(r_bal) - 32'(r_vel) - 32'(r_trn);
        end
    end

    // ------------------------------------------------------------------
    // Clamp, split into direction and duty, hold for the transfer
    // ------------------------------------------------------------------
    logic signed [31:0]        lim;
    logic signed [31:0]        clamp_a, clamp_b;
    logic signed [31:0]        abs_a, abs_b;

    always_comb begin
        lim = 32'({17'd0, r_output_limit});
        if (r_mix_a > lim) begin
            clamp_a = lim;
        end else if (r_mix_a < -lim) begin
            clamp_a = -lim;
        end else begin
            clamp_a = r_mix_a;
        end
        if (r_mix_b > lim) begin
            clamp_b = lim;
        end else if (r_mix_b < -lim) begin
            clamp_b = -lim;
        end else begin
            clamp_b = r_mix_b;
        end
        abs_a = clamp_a[31] ? -clamp_a : clamp_a;
        abs_b = clamp_b[31] ? -clamp_b : clamp_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_a_rev  <= clamp_a[31];
            r_a_duty <= abs_a[14:0];
            r_b_rev  <= clamp_b[31];
            r_b_duty <= abs_b[14:0];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_motor_a_reverse = r_a_rev;
    assign o_motor_a_duty    = r_a_duty;
    assign o_motor_b_reverse = r_b_rev;
    assign o_motor_b_duty    = r_b_duty;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `BRMC_ASSERT_ALWAYS(a_speed_target_range, ((ST_W + 1)'(r_speed_target) <= ST_MAX) && ((ST_W + 1)'(r_speed_target) >= -ST_MAX), "speed target out of range")
    `BRMC_ASSERT_ALWAYS(a_integ_range, (33'(r_integ) <= INTEG_MAX) && (33'(r_integ) >= -INTEG_MAX), "speed integral out of range")
    `BRMC_ASSERT_NEXT(a_transfer_starts_div, accept, div_busy, "divider not started by input transfer")
    `BRMC_ASSERT_SAME(a_quot_ready_at_filt, r_state == S_FILT, !div_busy, "filter update before divide finished")
    `BRMC_ASSERT_NEXT(a_out_hold_stalled, (r_state == S_OUT) && r_out_valid && !i_ready, r_state == S_OUT, "result overwrote a pending output")

endmodule
